FILE: hw/rtl/olids_pkg.sv
// olids_pkg: shared codes, types and the microcode store for the ordered list core.
// No dependencies; imported by olids_seq, olids_dp and the top level.
`timescale 1ns / 1ps
package olids_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int OP_W         = 2;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 5;
  localparam int ST_W         = 2;
  localparam int FIDX_W       = 4;
  localparam int CNT_OUT_W    = 5;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd3;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_MISS   = 2'd3;

  typedef logic [3:0] act_t;
  typedef logic [3:0] cond_t;
  typedef logic [4:0] pc_t;

  // datapath actions
  localparam act_t A_NOP        = 4'd0;
  localparam act_t A_LOAD       = 4'd1;
  localparam act_t A_SRCH_START = 4'd2;
  localparam act_t A_SRCH       = 4'd3;
  localparam act_t A_SET_MISS   = 4'd4;
  localparam act_t A_APP_WR     = 4'd5;
  localparam act_t A_INS_START  = 4'd6;
  localparam act_t A_INS_SHIFT  = 4'd7;
  localparam act_t A_INS_WR     = 4'd8;
  localparam act_t A_DEL_START  = 4'd9;
  localparam act_t A_DEL_SHIFT  = 4'd10;
  localparam act_t A_DEL_END    = 4'd11;
  localparam act_t A_SET_BADPOS = 4'd12;
  localparam act_t A_SET_FULL   = 4'd13;
  localparam act_t A_EMIT       = 4'd14;

  // jump conditions; a false condition falls through to the next step
  localparam cond_t C_ALWAYS    = 4'd0;
  localparam cond_t C_NO_IN     = 4'd1;
  localparam cond_t C_OP_APP    = 4'd2;
  localparam cond_t C_OP_INS    = 4'd3;
  localparam cond_t C_OP_DEL    = 4'd4;
  localparam cond_t C_CNT_ZERO  = 4'd5;
  localparam cond_t C_FULL      = 4'd6;
  localparam cond_t C_POS_GT    = 4'd7;
  localparam cond_t C_POS_GE    = 4'd8;
  localparam cond_t C_INS_MORE  = 4'd9;
  localparam cond_t C_DEL_NOSH  = 4'd10;
  localparam cond_t C_DEL_MORE  = 4'd11;
  localparam cond_t C_SRCH_MORE = 4'd12;
  localparam cond_t C_OUT_BUSY  = 4'd13;

  // program addresses
  localparam pc_t P_EMIT  = 5'd0;
  localparam pc_t P_IDLE  = 5'd1;
  localparam pc_t P_SRCH  = 5'd5;
  localparam pc_t P_SLOOP = 5'd6;
  localparam pc_t P_MISS  = 5'd8;
  localparam pc_t P_APP   = 5'd9;
  localparam pc_t P_INS   = 5'd11;
  localparam pc_t P_ILOOP = 5'd14;
  localparam pc_t P_IWR   = 5'd15;
  localparam pc_t P_DEL   = 5'd16;
  localparam pc_t P_DLOOP = 5'd18;
  localparam pc_t P_DEND  = 5'd19;
  localparam pc_t P_BAD   = 5'd20;
  localparam pc_t P_FULL  = 5'd21;

  typedef struct packed {
    act_t  act;
    cond_t cnd;
    pc_t   tgt;
  } ucode_t;

  typedef struct packed {
    logic no_in;
    logic op_app;
    logic op_ins;
    logic op_del;
    logic cnt_zero;
    logic full;
    logic pos_gt;
    logic pos_ge;
    logic ins_more;
    logic del_nosh;
    logic del_more;
    logic srch_more;
    logic out_busy;
  } cond_flags_t;

  function automatic ucode_t uw(input act_t a, input cond_t c, input pc_t t);
    ucode_t w;
    w.act = a;
    w.cnd = c;
    w.tgt = t;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    unique case (pc)
      5'd0:    w = uw(A_EMIT,       C_OUT_BUSY,  P_EMIT);
      5'd1:    w = uw(A_LOAD,       C_NO_IN,     P_IDLE);
      5'd2:    w = uw(A_NOP,        C_OP_APP,    P_APP);
      5'd3:    w = uw(A_NOP,        C_OP_INS,    P_INS);
      5'd4:    w = uw(A_NOP,        C_OP_DEL,    P_DEL);
      5'd5:    w = uw(A_SRCH_START, C_CNT_ZERO,  P_MISS);
      5'd6:    w = uw(A_SRCH,       C_SRCH_MORE, P_SLOOP);
      5'd7:    w = uw(A_NOP,        C_ALWAYS,    P_EMIT);
      5'd8:    w = uw(A_SET_MISS,   C_ALWAYS,    P_EMIT);
      5'd9:    w = uw(A_NOP,        C_FULL,      P_FULL);
      5'd10:   w = uw(A_APP_WR,     C_ALWAYS,    P_EMIT);
      5'd11:   w = uw(A_NOP,        C_POS_GT,    P_BAD);
      5'd12:   w = uw(A_NOP,        C_FULL,      P_FULL);
      5'd13:   w = uw(A_INS_START,  C_POS_GE,    P_IWR);
      5'd14:   w = uw(A_INS_SHIFT,  C_INS_MORE,  P_ILOOP);
      5'd15:   w = uw(A_INS_WR,     C_ALWAYS,    P_EMIT);
      5'd16:   w = uw(A_NOP,        C_POS_GE,    P_BAD);
      5'd17:   w = uw(A_DEL_START,  C_DEL_NOSH,  P_DEND);
      5'd18:   w = uw(A_DEL_SHIFT,  C_DEL_MORE,  P_DLOOP);
      5'd19:   w = uw(A_DEL_END,    C_ALWAYS,    P_EMIT);
      5'd20:   w = uw(A_SET_BADPOS, C_ALWAYS,    P_EMIT);
      5'd21:   w = uw(A_SET_FULL,   C_ALWAYS,    P_EMIT);
      default: w = uw(A_NOP,        C_ALWAYS,    P_IDLE);
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/olids_ram.sv
// olids_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module olids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/olids_seq.sv
// olids_seq: step counter and microcode store; picks the next step from the flags.
// Depends on olids_pkg.
`timescale 1ns / 1ps
module olids_seq
  import olids_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cond_flags_t flags,
  output act_t        act,
  output logic        idle
);

  pc_t    pc_r;
  pc_t    pc_nxt;
  ucode_t uc;
  logic   take;

  assign uc = ucode_rom(pc_r);

  always_comb begin
    unique case (uc.cnd)
      C_ALWAYS:    take = 1'b1;
      C_NO_IN:     take = flags.no_in;
      C_OP_APP:    take = flags.op_app;
      C_OP_INS:    take = flags.op_ins;
      C_OP_DEL:    take = flags.op_del;
      C_CNT_ZERO:  take = flags.cnt_zero;
      C_FULL:      take = flags.full;
      C_POS_GT:    take = flags.pos_gt;
      C_POS_GE:    take = flags.pos_ge;
      C_INS_MORE:  take = flags.ins_more;
      C_DEL_NOSH:  take = flags.del_nosh;
      C_DEL_MORE:  take = flags.del_more;
      C_SRCH_MORE: take = flags.srch_more;
      C_OUT_BUSY:  take = flags.out_busy;
      default:     take = 1'b1;
    endcase
    pc_nxt = take ? uc.tgt : pc_r + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= P_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign act  = uc.act;
  assign idle = (pc_r == P_IDLE);

endmodule

FILE: hw/rtl/olids_dp.sv
// olids_dp: request registers, entry count, walk index, result register and RAM control.
// Depends on olids_pkg; drives an olids_ram instance held by the top level.
`timescale 1ns / 1ps
module olids_dp
  import olids_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  act_t                        act,
  output cond_flags_t                 flags,
  input  logic                        in_valid,
  input  logic [OP_W-1:0]             in_op,
  input  logic signed [VAL_W-1:0]     in_value,
  input  logic [POS_W-1:0]            in_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ST_W-1:0]             out_status,
  output logic [FIDX_W-1:0]           out_found_index,
  output logic [CNT_OUT_W-1:0]        out_count_after,
  output logic                        ram_we,
  output logic [$clog2(CAPACITY)-1:0] ram_waddr,
  output logic [VAL_W-1:0]            ram_wdata,
  output logic [$clog2(CAPACITY)-1:0] ram_raddr,
  input  logic [VAL_W-1:0]            ram_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [OP_W-1:0]      op_r;
  logic [VAL_W-1:0]     val_r;
  logic [POS_W-1:0]     pos_r;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [ST_W-1:0]      status_r;
  logic [FIDX_W-1:0]    found_r;
  logic                 out_valid_r;
  logic [ST_W-1:0]      out_status_r;
  logic [FIDX_W-1:0]    out_found_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;

  logic [XW-1:0] cnt_x, idx_x, pos_x;
  logic          match;
  logic          out_busy;

  assign cnt_x    = {{(XW-CW){1'b0}}, cnt_r};
  assign idx_x    = {{(XW-CW){1'b0}}, idx_r};
  assign pos_x    = {{(XW-POS_W){1'b0}}, pos_r};
  assign match    = (ram_rdata == val_r);
  assign out_busy = out_valid_r && out_stall;

  always_comb begin
    flags.no_in     = !in_valid;
    flags.op_app    = (op_r == OP_APPEND);
    flags.op_ins    = (op_r == OP_INSERT);
    flags.op_del    = (op_r == OP_DELETE);
    flags.cnt_zero  = (cnt_x == '0);
    flags.full      = (cnt_x == XW'(CAPACITY));
    flags.pos_gt    = (pos_x > cnt_x);
    flags.pos_ge    = (pos_x >= cnt_x);
    flags.ins_more  = (idx_x > pos_x + XW'(1));
    flags.del_nosh  = (pos_x + XW'(1) >= cnt_x);
    flags.del_more  = (idx_x + XW'(2) < cnt_x);
    flags.srch_more = !match && (idx_x + XW'(1) < cnt_x);
    flags.out_busy  = out_busy;
  end

  // RAM port and index/count update
  always_comb begin
    logic [XW-1:0] ra;
    ra        = '0;
    ram_we    = 1'b0;
    ram_waddr = idx_x[AW-1:0];
    ram_wdata = ram_rdata;
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    case (act)
      A_SRCH_START: begin
        idx_nxt = '0;
      end
      A_SRCH: begin
        ra      = idx_x + XW'(1);
        idx_nxt = idx_r + CW'(1);
      end
      A_APP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_x[AW-1:0];
        ram_wdata = val_r;
        cnt_nxt   = cnt_r + CW'(1);
      end
      A_INS_START: begin
        ra      = cnt_x - XW'(1);
        idx_nxt = cnt_r;
      end
      A_INS_SHIFT: begin
        ram_we  = 1'b1;
        ra      = idx_x - XW'(2);
        idx_nxt = idx_r - CW'(1);
      end
      A_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_x[AW-1:0];
        ram_wdata = val_r;
        cnt_nxt   = cnt_r + CW'(1);
      end
      A_DEL_START: begin
        ra      = pos_x + XW'(1);
        idx_nxt = pos_x[CW-1:0];
      end
      A_DEL_SHIFT: begin
        ram_we  = 1'b1;
        ra      = idx_x + XW'(2);
        idx_nxt = idx_r + CW'(1);
      end
      A_DEL_END: begin
        cnt_nxt = cnt_r - CW'(1);
      end
      default: begin
      end
    endcase
    ram_raddr = ra[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (act == A_EMIT && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    case (act)
      A_LOAD: begin
        if (in_valid) begin
          op_r     <= in_op;
          val_r    <= in_value;
          pos_r    <= in_position;
          status_r <= ST_OK;
          found_r  <= '0;
        end
      end
      A_SRCH: begin
        status_r <= match ? ST_OK : ST_MISS;
        found_r  <= match ? idx_x[FIDX_W-1:0] : '0;
      end
      A_SET_MISS:   status_r <= ST_MISS;
      A_SET_BADPOS: status_r <= ST_BADPOS;
      A_SET_FULL:   status_r <= ST_FULL;
      A_EMIT: begin
        if (!out_busy) begin
          out_status_r <= status_r;
          out_found_r  <= found_r;
          out_cnt_r    <= cnt_x[CNT_OUT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = out_found_r;
  assign out_count_after = out_cnt_r;

endmodule

FILE: hw/rtl/ordered_list_insert_delete_search_core.sv
// ordered_list_insert_delete_search_core: top level of the ordered list engine.
// Depends on olids_pkg, olids_seq, olids_dp and olids_ram.
//
// Usage:
//   Input channel (in_valid/in_stall): one beat per request carrying in_op
//   (append, insert, delete, search), in_value and in_position.
//   Result channel (out_valid/out_stall): one beat per request with
//   out_status, out_found_index and out_count_after.
//   A microcoded sequencer runs one request at a time; in_stall is low only
//   while it sits at its idle step. A request takes longer the more entries
//   it walks: the entry store has one write and one registered read port, so
//   shifting or searching moves one entry a cycle. The longest requests are a
//   search over a full list and a delete at the head of a full list.
//   The result sits in an output register; the next request is taken while it
//   waits, and the next result waits at the emit step while out_stall holds.
//   Reset clears the entry count and the result valid; entry contents are not
//   cleared and are only read once written.
`timescale 1ns / 1ps
module ordered_list_insert_delete_search_core
  import olids_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_op,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [POS_W-1:0]        in_position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ST_W-1:0]         out_status,
  output logic [FIDX_W-1:0]       out_found_index,
  output logic [CNT_OUT_W-1:0]    out_count_after
);

  localparam int AW = $clog2(CAPACITY);

  act_t             act;
  cond_flags_t      flags;
  logic             idle;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [VAL_W-1:0] ram_rdata;

  olids_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .act   (act),
    .idle  (idle)
  );

  olids_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .act             (act),
    .flags           (flags),
    .in_valid        (in_valid),
    .in_op           (in_op),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_count_after (out_count_after),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  olids_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = !idle;

endmodule

FILE: hw/rtl/olids_chk.sv
// olids_chk: port-level checks for the ordered list core, bound to the top level.
// Depends on olids_pkg and ordered_list_insert_delete_search_core.
`timescale 1ns / 1ps
module olids_chk
  import olids_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [ST_W-1:0]   out_status,
  input logic [FIDX_W-1:0] out_found_index
);

  // found index only meaningful on a successful beat
  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_found_index == '0)
    else $error("found index set on a failed result");

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat accepted straight after the first");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("stalled result dropped or changed");

endmodule

bind ordered_list_insert_delete_search_core olids_chk u_chk (.*);

FILE: sim/tb.sv
// tb: self-checking bench for ordered_list_insert_delete_search_core.
// Keeps a shadow copy of the list in a small class and checks every result beat.
// Depends on olids_pkg and the core RTL only.
`timescale 1ns / 1ps
module tb;
  import olids_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 2000;

  class list_shadow;
    typedef struct packed {
      logic [ST_W-1:0]      status;
      logic [FIDX_W-1:0]    found_index;
      logic [CNT_OUT_W-1:0] count_after;
    } reply_t;

    logic signed [VAL_W-1:0] slots [DEF_CAPACITY];
    int unsigned fill;
    int unsigned mismatches;
    reply_t replies_due [$];

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function void take_request(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] value,
                               input logic [POS_W-1:0] pos);
      reply_t r;
      int i;
      r = '0;
      case (op)
        OP_APPEND: begin
          if (fill >= DEF_CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            slots[fill] = value;
            fill++;
            r.status = ST_OK;
          end
        end
        OP_INSERT: begin
          if (pos > fill) begin
            r.status = ST_BADPOS;
          end else if (fill >= DEF_CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (i = int'(fill); i > int'(pos); i--) slots[i] = slots[i-1];
            slots[pos] = value;
            fill++;
            r.status = ST_OK;
          end
        end
        OP_DELETE: begin
          if (pos >= fill) begin
            r.status = ST_BADPOS;
          end else begin
            for (i = int'(pos); i + 1 < int'(fill); i++) slots[i] = slots[i+1];
            fill--;
            r.status = ST_OK;
          end
        end
        default: begin
          // walk down so the lowest matching index is the one kept
          r.status = ST_MISS;
          for (i = int'(fill) - 1; i >= 0; i--) begin
            if (slots[i] == value) begin
              r.status = ST_OK;
              r.found_index = i[FIDX_W-1:0];
            end
          end
        end
      endcase
      r.count_after = fill[CNT_OUT_W-1:0];
      replies_due.push_back(r);
    endfunction

    function void match_result(input logic [ST_W-1:0] status, input logic [FIDX_W-1:0] fidx,
                               input logic [CNT_OUT_W-1:0] cnt);
      reply_t r;
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d index=%0d count=%0d",
                 $time, status, fidx, cnt);
        mismatches++;
      end else begin
        r = replies_due.pop_front();
        if (status !== r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, r.status, status);
          mismatches++;
        end
        if (fidx !== r.found_index) begin
          $display("%0t: found_index expected %0d actual %0d", $time, r.found_index, fidx);
          mismatches++;
        end
        if (cnt !== r.count_after) begin
          $display("%0t: count_after expected %0d actual %0d", $time, r.count_after, cnt);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         in_op = OP_APPEND;
  logic signed [VAL_W-1:0] in_value = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [ST_W-1:0]         out_status;
  logic [FIDX_W-1:0]       out_found_index;
  logic [CNT_OUT_W-1:0]    out_count_after;

  logic calm = 1'b0;
  int   cycle_count = 0;
  list_shadow shadow = new();

  ordered_list_insert_delete_search_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_count_after (out_count_after)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL ordered_list_insert_delete_search_core");
      $finish;
    end else begin
      if (rst_n && out_valid && !out_stall)
        shadow.match_result(out_status, out_found_index, out_count_after);
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 25);
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] value,
                              input logic [POS_W-1:0] pos);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_value    <= value;
    in_position <= pos;
    do @(posedge clk); while (in_stall);
    shadow.take_request(op, value, pos);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      case ($urandom_range(3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return -32'sd1;
        default: return 32'sd0;
      endcase
    end else if (roll < 40) begin
      return $signed($urandom_range(7)) - 32'sd3;
    end
    return $urandom();
  endfunction

  task automatic random_traffic(input int n);
    int k;
    int unsigned roll, cnt;
    bit grow;
    logic [OP_W-1:0] op;
    logic signed [VAL_W-1:0] v;
    logic [POS_W-1:0] p;
    for (k = 0; k < n; k++) begin
      if (k == 1000) calm <= 1'b1;
      if (k == 1300) calm <= 1'b0;
      grow = ((k / 150) % 2) == 0;
      cnt  = shadow.fill;
      roll = $urandom_range(99);
      v    = pick_value();
      p    = POS_W'($urandom_range(16));
      if (roll < 5) begin
        op = OP_W'($urandom_range(3));
        v  = $urandom();
      end else begin
        roll = $urandom_range(99);
        if (grow)
          op = roll < 30 ? OP_APPEND : roll < 60 ? OP_INSERT : roll < 75 ? OP_DELETE : OP_SEARCH;
        else
          op = roll < 10 ? OP_APPEND : roll < 25 ? OP_INSERT : roll < 70 ? OP_DELETE : OP_SEARCH;
        if (op == OP_INSERT && $urandom_range(99) < 85)
          p = POS_W'($urandom_range(cnt));
        if (op == OP_DELETE && cnt > 0 && $urandom_range(99) < 85)
          p = POS_W'($urandom_range(cnt - 1));
        if (op == OP_SEARCH && cnt > 0 && $urandom_range(99) < 60)
          v = shadow.slots[$urandom_range(cnt - 1)];
      end
      send_request(op, v, p);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list corners
    send_request(OP_SEARCH, 32'sd5, 5'd0);
    send_request(OP_DELETE, 32'sd0, 5'd0);
    send_request(OP_INSERT, 32'sd1, 5'd1);
    send_request(OP_INSERT, 32'sh8000_0000, 5'd0);
    send_request(OP_APPEND, 32'sh7fff_ffff, 5'd31);
    send_request(OP_APPEND, -32'sd1, 5'd16);
    send_request(OP_INSERT, -32'sd1, 5'd1);
    send_request(OP_SEARCH, -32'sd1, 5'd16);
    send_request(OP_SEARCH, 32'sh8000_0000, 5'd0);
    send_request(OP_SEARCH, 32'sd12345, 5'd0);
    send_request(OP_INSERT, 32'sd0, 5'd4);
    send_request(OP_INSERT, 32'sd9, 5'd6);
    send_request(OP_DELETE, 32'sd0, 5'd5);
    send_request(OP_DELETE, 32'sd0, 5'd0);
    while (shadow.fill < DEF_CAPACITY) send_request(OP_APPEND, $urandom(), 5'd0);
    // full list corners
    send_request(OP_APPEND, 32'sd7, 5'd0);
    send_request(OP_INSERT, 32'sd7, 5'd16);
    send_request(OP_INSERT, 32'sd7, 5'd3);
    send_request(OP_DELETE, 32'sd0, 5'd16);
    send_request(OP_SEARCH, 32'sh7fff_ffff, 5'd0);
    send_request(OP_DELETE, 32'sd0, 5'd15);
    send_request(OP_DELETE, 32'sd0, 5'd0);

    random_traffic(RANDOM_ITEMS);

    in_valid <= 1'b0;
    while (shadow.replies_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.replies_due.size() == 0)
      $display("PASS ordered_list_insert_delete_search_core");
    else
      $display("FAIL ordered_list_insert_delete_search_core");
    $finish;
  end

endmodule
